// ===== rtl/mrlf_pkg.sv =====
// Shared types and constants of the mesh route-learn-forward block.
package mrlf_pkg;

	localparam int ROUTE_ENTRIES = 256;
	localparam int IDX_W = $clog2(ROUTE_ENTRIES);
	localparam int SEEN_DEPTH_DEF = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int KEY_W = 16;

	localparam logic [7:0] NODE_ADDR_RST = 8'd1;
	localparam logic [7:0] SIG_VALUE_RST = 8'd165;
	localparam logic [7:0] DIST_RST = 8'hFF;

	localparam logic OP_RX = 1'b0;
	localparam logic OP_TX = 1'b1;

	localparam logic REG_NODE_ADDR = 1'b0;
	localparam logic REG_SIG_VALUE = 1'b1;

	localparam logic [1:0] ACT_DROP = 2'd0;
	localparam logic [1:0] ACT_DELIVER = 2'd1;
	localparam logic [1:0] ACT_TX = 2'd2;

	// classified item, front to back
	typedef struct packed {
		logic is_tx;
		logic early_drop;
		logic addressed;
		logic local_dst;
		logic [7:0] id;
		logic [7:0] origin;
		logic [7:0] sender;
		logic [7:0] fin;
		logic [7:0] hops;
		logic [7:0] len;
	} cmd_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] id;
		logic [7:0] origin;
		logic [7:0] sender;
		logic [7:0] next;
		logic [7:0] fin;
		logic [7:0] hops;
		logic [7:0] len;
	} res_t;

endpackage

// ===== rtl/mesh_route_learn_forward_top.sv =====
// Top level of the mesh route-learn-forward block.
//
//  channel   handshake          payload
//  input     push / full        operation, sig_byte, msg_id, origin_addr, sender_addr,
//                               next_addr, final_addr, hop_count, frame_length
//  result    pop / empty        action, out_id .. out_length
//  config    cfg_we             cfg_index, cfg_data
//
// The back end handles one item at a time: queue pop, table and ring read, execute
// with table/ring update, result register load. The single-port route table
// read-modify-write sets this order. Reset is immediate: route entries carry valid
// bits, so no clearing pass. The two-entry queue lets items be taken while a result
// waits; full rises once it fills, when items come faster than the back end takes
// them or pile up behind a stalled result.
module mesh_route_learn_forward_top import mrlf_pkg::*; #(
	parameter int SEEN_DEPTH = SEEN_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       push,
	output logic       full,
	input  logic       operation,
	input  logic [7:0] sig_byte,
	input  logic [7:0] msg_id,
	input  logic [7:0] origin_addr,
	input  logic [7:0] sender_addr,
	input  logic [7:0] next_addr,
	input  logic [7:0] final_addr,
	input  logic [7:0] hop_count,
	input  logic [7:0] frame_length,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] action,
	output logic [7:0] out_id,
	output logic [7:0] out_origin,
	output logic [7:0] out_sender,
	output logic [7:0] out_next,
	output logic [7:0] out_final,
	output logic [7:0] out_hops,
	output logic [7:0] out_length
);

	logic [7:0] node_q, sig_q;
	cmd_t cmd, q_data;
	logic q_empty, q_pop, res_valid;
	res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_q <= NODE_ADDR_RST;
			sig_q <= SIG_VALUE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NODE_ADDR: node_q <= cfg_data;
				REG_SIG_VALUE: sig_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mrlf_front u_front (
		.own_addr        (node_q),
		.signature_value (sig_q),
		.operation       (operation),
		.sig_byte        (sig_byte),
		.msg_id          (msg_id),
		.origin_addr     (origin_addr),
		.sender_addr     (sender_addr),
		.next_addr       (next_addr),
		.final_addr      (final_addr),
		.hop_count       (hop_count),
		.frame_length    (frame_length),
		.cmd             (cmd)
	);

	mrlf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (cmd),
		.full    (full),
		.rd_en   (q_pop),
		.rd_data (q_data),
		.empty   (q_empty)
	);

	mrlf_back #(
		.SEEN_DEPTH (SEEN_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.own_addr     (node_q),
		.q_data       (q_data),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.res          (res),
		.res_valid    (res_valid),
		.res_pop      (pop)
	);

	assign empty = !res_valid;
	assign action = res.action;
	assign out_id = res.id;
	assign out_origin = res.origin;
	assign out_sender = res.sender;
	assign out_next = res.next;
	assign out_final = res.fin;
	assign out_hops = res.hops;
	assign out_length = res.len;

endmodule

// ===== rtl/mrlf_front.sv =====
// Front end: classifies an incoming header against this node's settings.
module mrlf_front import mrlf_pkg::*; (
	input  logic [7:0] own_addr,
	input  logic [7:0] signature_value,
	input  logic       operation,
	input  logic [7:0] sig_byte,
	input  logic [7:0] msg_id,
	input  logic [7:0] origin_addr,
	input  logic [7:0] sender_addr,
	input  logic [7:0] next_addr,
	input  logic [7:0] final_addr,
	input  logic [7:0] hop_count,
	input  logic [7:0] frame_length,
	output cmd_t       cmd
);

	always_comb begin
		cmd.is_tx = (operation == OP_TX);
		// bad signature or our own frame coming back
		cmd.early_drop = (sig_byte != signature_value) || (origin_addr == own_addr);
		cmd.addressed = (next_addr == 8'd0) || (next_addr == own_addr);
		cmd.local_dst = (final_addr == own_addr);
		cmd.id = msg_id;
		cmd.origin = origin_addr;
		cmd.sender = sender_addr;
		cmd.fin = final_addr;
		cmd.hops = hop_count;
		cmd.len = frame_length;
	end

endmodule

// ===== rtl/mrlf_queue.sv =====
// Short item queue between front and back.
module mrlf_queue import mrlf_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_data,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_data,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr, do_rd;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/mrlf_back.sv =====
// Back end: route table, seen-key ring, message counter and result register.
module mrlf_back import mrlf_pkg::*; #(
	parameter int SEEN_DEPTH = SEEN_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] own_addr,
	input  cmd_t       q_data,
	input  logic       q_empty,
	output logic       q_pop,
	output res_t       res,
	output logic       res_valid,
	input  logic       res_pop
);

	localparam int PTR_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;

	typedef enum logic [1:0] {B_IDLE, B_READ, B_EXEC, B_OUT} state_t;

	state_t state_q;
	cmd_t cmd_q;
	res_t res_q, out_q, res_d;
	logic out_valid_q;

	logic [7:0] nh_mem [ROUTE_ENTRIES];
	logic [7:0] dist_mem [ROUTE_ENTRIES];
	logic [ROUTE_ENTRIES-1:0] valid_q;
	logic [7:0] dist_rd_q, nh_rd_q;
	logic vo_q, vf_q;

	logic [KEY_W-1:0] seen_q [SEEN_DEPTH];
	logic [SEEN_DEPTH-1:0] hit_q;
	logic [PTR_W-1:0] wptr_q;
	logic [7:0] ctr_q;

	logic [IDX_W-1:0] idx_o, idx_f;
	logic [KEY_W-1:0] key;
	logic [7:0] dist_o, next_f, ctr_inc;
	logic learn, accept, dup, exec;

	// address a uses entry a-1, so address 0 wraps to the last entry
	assign idx_o = IDX_W'(cmd_q.origin - 8'd1);
	assign idx_f = IDX_W'(cmd_q.fin - 8'd1);
	assign key = {cmd_q.id, cmd_q.origin};
	assign exec = (state_q == B_EXEC);
	assign q_pop = (state_q == B_IDLE) && !q_empty;

	always_comb begin
		dist_o = vo_q ? dist_rd_q : DIST_RST;
		learn = !cmd_q.is_tx && !cmd_q.early_drop && (dist_o > cmd_q.hops);
		// lookup sees this item's own route update
		if (learn && (idx_o == idx_f)) begin
			next_f = cmd_q.sender;
		end else begin
			next_f = vf_q ? nh_rd_q : 8'd0;
		end
		dup = |hit_q;
		accept = !cmd_q.is_tx && !cmd_q.early_drop && cmd_q.addressed && !dup;
		ctr_inc = ctr_q + 8'd1;
		res_d = '0;
		res_d.action = ACT_DROP;
		if (cmd_q.is_tx) begin
			res_d.action = ACT_TX;
			res_d.id = ctr_inc;
			res_d.origin = own_addr;
			res_d.sender = own_addr;
			res_d.next = next_f;
			res_d.fin = cmd_q.fin;
			res_d.hops = 8'd0;
			res_d.len = cmd_q.len;
		end else if (accept && cmd_q.local_dst) begin
			res_d.action = ACT_DELIVER;
		end else if (accept) begin
			res_d.action = ACT_TX;
			res_d.id = cmd_q.id;
			res_d.origin = cmd_q.origin;
			res_d.sender = own_addr;
			res_d.next = next_f;
			res_d.fin = cmd_q.fin;
			res_d.hops = cmd_q.hops + 8'd1;
			res_d.len = cmd_q.len;
		end
	end

	// route table storage, registered reads
	always_ff @(posedge clk) begin
		if (exec && learn) begin
			nh_mem[idx_o] <= cmd_q.sender;
			dist_mem[idx_o] <= cmd_q.hops;
		end
		if (state_q == B_READ) begin
			dist_rd_q <= dist_mem[idx_o];
			nh_rd_q <= nh_mem[idx_f];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_data;
		end
		if (state_q == B_READ) begin
			for (int i = 0; i < SEEN_DEPTH; i++) begin
				hit_q[i] <= (seen_q[i] == key);
			end
		end
		if (exec) begin
			res_q <= res_d;
		end
		if ((state_q == B_OUT) && (!out_valid_q || res_pop)) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			valid_q <= '0;
			vo_q <= 1'b0;
			vf_q <= 1'b0;
			wptr_q <= '0;
			ctr_q <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SEEN_DEPTH; i++) begin
				seen_q[i] <= '0;
			end
		end else begin
			// a new item loads as the old one leaves, so valid stays up
			if ((state_q == B_OUT) && (!out_valid_q || res_pop)) begin
				out_valid_q <= 1'b1;
			end else if (res_pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (!q_empty) begin
						state_q <= B_READ;
					end
				end
				B_READ: begin
					vo_q <= valid_q[idx_o];
					vf_q <= valid_q[idx_f];
					state_q <= B_EXEC;
				end
				B_EXEC: begin
					if (learn) begin
						valid_q[idx_o] <= 1'b1;
					end
					if (accept) begin
						seen_q[wptr_q] <= key;
						wptr_q <= (wptr_q == PTR_W'(SEEN_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
					end
					if (cmd_q.is_tx) begin
						ctr_q <= ctr_inc;
					end
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (!out_valid_q || res_pop) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign res = out_q;
	assign res_valid = out_valid_q;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the mesh route-learn-forward block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mrlf_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int PHASE_ITEMS = 206;

	typedef struct packed {
		logic       op;
		logic [7:0] sig;
		logic [7:0] id;
		logic [7:0] origin;
		logic [7:0] sender;
		logic [7:0] next;
		logic [7:0] fin;
		logic [7:0] hops;
		logic [7:0] len;
	} frame_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = REG_NODE_ADDR;
	logic [7:0] cfg_data = 8'd0;
	logic       push = 1'b0;
	logic       full;
	logic       operation;
	logic [7:0] sig_byte, msg_id, origin_addr, sender_addr, next_addr;
	logic [7:0] final_addr, hop_count, frame_length;
	logic       empty;
	logic       pop = 1'b0;
	logic [1:0] action;
	logic [7:0] out_id, out_origin, out_sender, out_next, out_final, out_hops, out_length;

	frame_t     cur = '0;
	frame_t     pending_frames[$];
	res_t       expected_verdicts[$];
	res_t       want;
	logic [15:0] recent_keys[$];
	logic       frame_taken = 1'b0;
	logic       steady = 1'b0;
	int         errors = 0;
	int         stall_cycles = 0;

	// predictor state and register copies
	logic [7:0]  hop_table [ROUTE_ENTRIES];
	logic [7:0]  dist_table [ROUTE_ENTRIES];
	logic [15:0] seen_ring [SEEN_DEPTH_DEF];
	int          ring_ptr;
	logic [7:0]  own_counter;
	logic [7:0]  node_cfg;
	logic [7:0]  sig_cfg;

	assign operation = cur.op;
	assign sig_byte = cur.sig;
	assign msg_id = cur.id;
	assign origin_addr = cur.origin;
	assign sender_addr = cur.sender;
	assign next_addr = cur.next;
	assign final_addr = cur.fin;
	assign hop_count = cur.hops;
	assign frame_length = cur.len;

	mesh_route_learn_forward_top #(.SEEN_DEPTH(SEEN_DEPTH_DEF)) dut (.*);

	always #4 clk = ~clk;

	function automatic res_t route_verdict(input frame_t f);
		res_t r;
		logic [7:0] slot;
		logic [15:0] key;
		r = '0;
		if (f.op == OP_TX) begin
			own_counter = own_counter + 8'd1;
			slot = f.fin - 8'd1;
			r.action = ACT_TX;
			r.id = own_counter;
			r.origin = node_cfg;
			r.sender = node_cfg;
			r.next = hop_table[slot];
			r.fin = f.fin;
			r.hops = 8'd0;
			r.len = f.len;
			return r;
		end
		if (f.sig != sig_cfg || f.origin == node_cfg)
			return r;
		slot = f.origin - 8'd1;
		if (dist_table[slot] > f.hops) begin
			hop_table[slot] = f.sender;
			dist_table[slot] = f.hops;
		end
		if (f.next != 8'd0 && f.next != node_cfg)
			return r;
		key = {f.id, f.origin};
		for (int i = 0; i < SEEN_DEPTH_DEF; i++)
			if (seen_ring[i] == key)
				return r;
		seen_ring[ring_ptr] = key;
		ring_ptr = (ring_ptr + 1) % SEEN_DEPTH_DEF;
		if (f.fin == node_cfg) begin
			r.action = ACT_DELIVER;
			return r;
		end
		// route lookup sees this frame's own learning
		slot = f.fin - 8'd1;
		r.action = ACT_TX;
		r.id = f.id;
		r.origin = f.origin;
		r.sender = node_cfg;
		r.next = hop_table[slot];
		r.fin = f.fin;
		r.hops = f.hops + 8'd1;
		r.len = f.len;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s expected %0h got %0h", $time, name, exp_v, got_v);
			errors++;
		end
	endfunction

	function automatic frame_t noise_frame();
		frame_t f;
		f.op = 1'($urandom);
		f.sig = 8'($urandom);
		f.id = 8'($urandom);
		f.origin = 8'($urandom);
		f.sender = 8'($urandom);
		f.next = 8'($urandom);
		f.fin = 8'($urandom);
		f.hops = 8'($urandom);
		f.len = 8'($urandom);
		return f;
	endfunction

	function automatic frame_t rx_frame(input logic [7:0] sig, id, origin, sender, next, fin,
			hops, len);
		frame_t f;
		f.op = OP_RX;
		f.sig = sig;
		f.id = id;
		f.origin = origin;
		f.sender = sender;
		f.next = next;
		f.fin = fin;
		f.hops = hops;
		f.len = len;
		return f;
	endfunction

	function automatic frame_t tx_frame(input logic [7:0] fin, len);
		frame_t f;
		f = noise_frame();
		f.op = OP_TX;
		f.fin = fin;
		f.len = len;
		return f;
	endfunction

	// small address pool so that routes and keys collide often
	function automatic logic [7:0] mesh_addr();
		int unsigned pick;
		pick = $urandom_range(11);
		if (pick == 10)
			return node_cfg;
		if (pick == 11)
			return 8'hFF;
		return 8'(pick);
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		logic [15:0] key;
		int unsigned pick;
		f = noise_frame();
		pick = $urandom_range(99);
		if (pick < 12)
			return f;
		if (pick < 40) begin
			f.op = OP_TX;
			f.fin = mesh_addr();
			return f;
		end
		f.op = OP_RX;
		if ($urandom_range(9) != 0)
			f.sig = sig_cfg;
		if ($urandom_range(4) == 0 && recent_keys.size() != 0) begin
			key = recent_keys[$urandom_range(recent_keys.size() - 1)];
			f.id = key[15:8];
			f.origin = key[7:0];
		end else begin
			f.origin = mesh_addr();
			if ($urandom_range(1) == 0)
				f.id = 8'($urandom_range(3));
			recent_keys.push_back({f.id, f.origin});
			if (recent_keys.size() > 24)
				void'(recent_keys.pop_front());
		end
		f.sender = mesh_addr();
		pick = $urandom_range(9);
		if (pick < 4)
			f.next = 8'd0;
		else if (pick < 8)
			f.next = node_cfg;
		f.fin = ($urandom_range(3) == 0) ? node_cfg : mesh_addr();
		if ($urandom_range(3) != 0)
			f.hops = 8'($urandom_range(7));
		return f;
	endfunction

	task automatic write_reg(input logic idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NODE_ADDR)
			node_cfg = val;
		else
			sig_cfg = val;
	endtask

	// wait until every item is through, then let the back end go quiet
	task automatic settle();
		while (pending_frames.size() != 0 || push || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// driver
	always @(negedge clk) begin
		if (!push || frame_taken) begin
			if (arst_n && pending_frames.size() != 0 && (steady || $urandom_range(99) >= 32)) begin
				cur <= pending_frames.pop_front();
				push <= 1'b1;
			end else
				push <= 1'b0;
		end
		pop <= arst_n && (steady || $urandom_range(99) >= 32);
	end

	// monitor, scoreboard and watchdog
	always @(posedge clk) begin
		frame_taken <= arst_n && push && !full;
		if (arst_n) begin
			if (push && !full)
				expected_verdicts.push_back(route_verdict(cur));
			if (pop && !empty) begin
				if (expected_verdicts.size() == 0) begin
					$display("%0t: result with no item outstanding", $time);
					errors++;
				end else begin
					want = expected_verdicts.pop_front();
					check_field("action", 8'(want.action), 8'(action));
					check_field("out_id", want.id, out_id);
					check_field("out_origin", want.origin, out_origin);
					check_field("out_sender", want.sender, out_sender);
					check_field("out_next", want.next, out_next);
					check_field("out_final", want.fin, out_final);
					check_field("out_hops", want.hops, out_hops);
					check_field("out_length", want.len, out_length);
				end
			end
			if ((push && !full) || (pop && !empty))
				stall_cycles <= 0;
			else if (stall_cycles >= STALL_LIMIT) begin
				$display("mesh_route_learn_forward_top verification failed");
				$finish;
			end else
				stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		for (int i = 0; i < ROUTE_ENTRIES; i++) begin
			hop_table[i] = 8'd0;
			dist_table[i] = DIST_RST;
		end
		for (int i = 0; i < SEEN_DEPTH_DEF; i++)
			seen_ring[i] = 16'd0;
		ring_ptr = 0;
		own_counter = 8'd0;
		node_cfg = NODE_ADDR_RST;
		sig_cfg = SIG_VALUE_RST;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, reset register values
		// zero key hits the cleared ring but still teaches the route to address 0
		pending_frames.push_back(rx_frame(8'd165, 8'd0, 8'd0, 8'd9, 8'd0, 8'd1, 8'd3, 8'd10));
		pending_frames.push_back(tx_frame(8'd0, 8'd255));
		pending_frames.push_back(rx_frame(8'h5A, 8'd1, 8'd2, 8'd3, 8'd0, 8'd1, 8'd0, 8'd0));
		pending_frames.push_back(rx_frame(8'd165, 8'd2, 8'd1, 8'd3, 8'd0, 8'd5, 8'd0, 8'd0));
		pending_frames.push_back(rx_frame(8'd165, 8'd3, 8'd2, 8'd7, 8'd4, 8'd5, 8'd2, 8'd20));
		pending_frames.push_back(rx_frame(8'd165, 8'd4, 8'd3, 8'd8, 8'd1, 8'd1, 8'd0, 8'd30));
		pending_frames.push_back(rx_frame(8'd165, 8'd4, 8'd3, 8'd8, 8'd1, 8'd1, 8'd0, 8'd30));
		pending_frames.push_back(rx_frame(8'd165, 8'd5, 8'd255, 8'd255, 8'd0, 8'd2, 8'd255,
			8'd255));
		pending_frames.push_back(rx_frame(8'd165, 8'd255, 8'd2, 8'd11, 8'd0, 8'd255, 8'd1, 8'd0));
		pending_frames.push_back(rx_frame(8'd165, 8'd6, 8'd2, 8'd12, 8'd0, 8'd2, 8'd1, 8'd1));
		pending_frames.push_back(rx_frame(8'd165, 8'd255, 8'd255, 8'd200, 8'd0, 8'd255, 8'd254,
			8'd128));
		pending_frames.push_back(tx_frame(8'd2, 8'd0));
		pending_frames.push_back(tx_frame(8'd255, 8'd1));
		pending_frames.push_back(rx_frame(8'd165, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0));
		pending_frames.push_back(tx_frame(8'd0, 8'd100));
		pending_frames.push_back(rx_frame(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
		pending_frames.push_back(rx_frame(8'd165, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
			8'd255, 8'd255));
		pending_frames.push_back(noise_frame());

		for (int p = 0; p < 5; p++) begin
			settle();
			case (p)
			0: begin
				write_reg(REG_NODE_ADDR, 8'hFF);
				write_reg(REG_SIG_VALUE, 8'h00);
			end
			1: begin
				// node address zero aliases the broadcast next hop
				write_reg(REG_NODE_ADDR, 8'h00);
				write_reg(REG_SIG_VALUE, 8'hFF);
			end
			2: begin
				write_reg(REG_NODE_ADDR, 8'($urandom_range(2, 254)));
				write_reg(REG_SIG_VALUE, 8'($urandom));
			end
			3: begin
				write_reg(REG_SIG_VALUE, SIG_VALUE_RST);
				write_reg(REG_NODE_ADDR, 8'($urandom_range(1, 254)));
			end
			default: begin
				write_reg(REG_NODE_ADDR, NODE_ADDR_RST);
				write_reg(REG_SIG_VALUE, 8'($urandom));
			end
			endcase
			steady = (p == 2);
			recent_keys.delete();
			repeat (PHASE_ITEMS) pending_frames.push_back(random_frame());
		end

		settle();
		repeat (12) @(posedge clk);
		if (errors == 0)
			$display("mesh_route_learn_forward_top verification clean");
		else
			$display("mesh_route_learn_forward_top verification failed");
		$finish;
	end

endmodule
